[sv/wmm_pkg.sv]
`timescale 1ns / 1ps
// wmm_pkg: shared types and constants of the word modular multiplier
// no dependencies; used by wmm_mod_pipe and word_modular_multiplier

package wmm_pkg;

  // reduction methods held in the mode register
  typedef enum logic [2:0] {
    MODE_MONTGOMERY = 3'd0,
    MODE_MERSENNE   = 3'd1,
    MODE_PSEUDO     = 3'd2,
    MODE_GENERAL    = 3'd3,
    MODE_FRIENDLY   = 3'd4,
    MODE_PLANTARD   = 3'd5
  } reduction_mode_t;

  // configuration register indexes
  localparam int CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REDUCTION_MODE   = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODULUS          = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INVERSE_CONSTANT = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FOLD_FACTOR      = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SHIFT_AMOUNT     = 3'd4;

  // field widths
  localparam int FIELD_WIDTH   = 32;
  localparam int INV_WIDTH     = 64;
  localparam int FOLD_WIDTH    = 16;
  localparam int SHIFT_WIDTH   = 5;
  localparam int EMASK_WIDTH   = 31;

  // register reset values
  localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET = 32'hFFFF_FFEF;
  localparam logic [FOLD_WIDTH-1:0]  FOLD_RESET    = 16'd17;
  localparam logic [SHIFT_WIDTH-1:0] SHIFT_RESET   = 5'd4;

  // final remainder unit: dividend width and quotient bits per stage
  localparam int DIV_WIDTH = 64;
  localparam int DIV_STEPS = 4;

endpackage

[sv/wmm_mod_pipe.sv]
`timescale 1ns / 1ps
// wmm_mod_pipe: pipelined restoring remainder of a 64-bit value by a word divisor
// depends on wmm_pkg (DIV_WIDTH, DIV_STEPS)

module wmm_mod_pipe #(
  parameter int WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [wmm_pkg::DIV_WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0]             divisor,
  input  logic                         force_zero,
  output logic                         out_valid,
  output logic [WIDTH-1:0]             remainder
);

  localparam int STAGES = wmm_pkg::DIV_WIDTH / wmm_pkg::DIV_STEPS;
  localparam int LAST   = STAGES - 1;

  logic [STAGES-1:0]             v_q;
  logic [STAGES-1:0]             z_q;
  logic [WIDTH-1:0]              rem_q [STAGES];
  logic [WIDTH-1:0]              rem_next [STAGES];
  logic [WIDTH-1:0]              d_q [STAGES];
  logic [wmm_pkg::DIV_WIDTH-1:0] num_q [STAGES];
  logic [wmm_pkg::DIV_WIDTH-1:0] num_next [STAGES];

  // DIV_STEPS shift-compare-subtract steps per stage
  always_comb begin
    logic [WIDTH-1:0]              r;
    logic [WIDTH-1:0]              d;
    logic [WIDTH:0]                re;
    logic [wmm_pkg::DIV_WIDTH-1:0] n;
    for (int s = 0; s < STAGES; s++) begin
      if (s == 0) begin
        r = '0;
        n = dividend;
        d = divisor;
      end else begin
        r = rem_q[s-1];
        n = num_q[s-1];
        d = d_q[s-1];
      end
      for (int j = 0; j < wmm_pkg::DIV_STEPS; j++) begin
        re = {r, n[wmm_pkg::DIV_WIDTH-1]};
        n  = n << 1;
        if (re >= {1'b0, d}) begin
          re = re - {1'b0, d};
        end
        r = re[WIDTH-1:0];
      end
      rem_next[s] = r;
      num_next[s] = n;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[STAGES-2:0], in_valid};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      d_q[0] <= divisor;
      z_q[0] <= force_zero;
      for (int s = 0; s < STAGES; s++) begin
        rem_q[s] <= rem_next[s];
        num_q[s] <= num_next[s];
      end
      for (int s = 1; s < STAGES; s++) begin
        d_q[s] <= d_q[s-1];
        z_q[s] <= z_q[s-1];
      end
    end
  end

  assign out_valid = v_q[LAST];
  assign remainder = z_q[LAST] ? '0 : rem_q[LAST];

  // a remainder not forced to zero always ends below its divisor
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !z_q[LAST]) |-> (rem_q[LAST] < d_q[LAST]))
    else $error("remainder not below divisor");

  // a held pipeline keeps its occupancy
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v_q))
    else $error("valid bits moved while held");

  // a forced item leaves as zero
  a_forced_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && z_q[LAST]) |-> (remainder == '0))
    else $error("forced item not zero");

endmodule

[sv/word_modular_multiplier.sv]
`timescale 1ns / 1ps
// word_modular_multiplier: top level, product pipeline, fold stages and config registers
// depends on wmm_pkg and wmm_mod_pipe
//
// Usage:
//   Items (operand_a, operand_b) enter on in_valid/in_stall and leave as residue
//   on out_valid/out_stall; an item moves when valid is high and stall is low.
//   Configuration registers are written over cfg_valid/cfg_ready with cfg_index
//   and cfg_data; cfg_ready is always high. The user must write them only while
//   no item is in flight; the block itself does not enforce this.
//   Pipeline: six stages for the product, the mode's multiplies and folds, then
//   sixteen stages of the remainder unit, which retires four quotient bits per stage.
//   Throughput: one item per cycle while no result is held at the output;
//   every stage holds one item and the multipliers and subtractors are all pipelined.
//   When out_stall holds a result the whole pipeline freezes; one more input
//   item is still taken into a skid register, after which in_stall rises until
//   the pipeline moves again.
//   Reset (rst, synchronous) empties the pipeline and loads the register
//   defaults: Montgomery mode, modulus 2^32-17, fold factor 17, shift 4.

module word_modular_multiplier #(
  parameter int WORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] residue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int W  = WORD_WIDTH;
  localparam int W2 = 2 * WORD_WIDTH;
  localparam int TW = wmm_pkg::DIV_WIDTH;
  localparam int KW = wmm_pkg::FOLD_WIDTH;
  localparam int EW = wmm_pkg::EMASK_WIDTH;

  // configuration registers
  wmm_pkg::reduction_mode_t            mode;
  logic [wmm_pkg::FIELD_WIDTH-1:0]     modulus;
  logic [wmm_pkg::INV_WIDTH-1:0]       inverse_constant;
  logic [KW-1:0]                       fold_factor;
  logic [wmm_pkg::SHIFT_WIDTH-1:0]     shift_amount;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= wmm_pkg::MODE_MONTGOMERY;
      modulus          <= wmm_pkg::MODULUS_RESET;
      inverse_constant <= '0;
      fold_factor      <= wmm_pkg::FOLD_RESET;
      shift_amount     <= wmm_pkg::SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wmm_pkg::CFG_REDUCTION_MODE:   mode <= wmm_pkg::reduction_mode_t'(cfg_data[2:0]);
        wmm_pkg::CFG_MODULUS:          modulus <= cfg_data[31:0];
        wmm_pkg::CFG_INVERSE_CONSTANT: inverse_constant <= cfg_data;
        wmm_pkg::CFG_FOLD_FACTOR:      fold_factor <= cfg_data[KW-1:0];
        wmm_pkg::CFG_SHIFT_AMOUNT:     shift_amount <= cfg_data[wmm_pkg::SHIFT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // derived constants of the active configuration
  logic [W-1:0]  p;
  logic [W-1:0]  q;
  logic [W-1:0]  rl;
  logic [W-1:0]  rh;
  logic [EW-1:0] em;

  assign p  = modulus[W-1:0];
  assign q  = inverse_constant[W-1:0];
  assign rl = inverse_constant[W-1:0];
  assign rh = inverse_constant[W2-1:W];
  assign em = (EW'(1) << shift_amount) - EW'(1);

  // handshake and skid register
  logic adv;
  logic in_acc;
  logic skid_v;
  logic [W-1:0] skid_a;
  logic [W-1:0] skid_b;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = skid_v;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (adv) begin
      skid_v <= 1'b0;
    end else if (in_acc) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_acc) begin
      skid_a <= operand_a[W-1:0];
      skid_b <= operand_b[W-1:0];
    end
  end

  // stage valid bits
  logic v1, v2, v3, v4, v5, v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v1 <= skid_v || in_acc;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // stage payload registers
  logic [W-1:0]    a1, b1;
  logic [W2-1:0]   prod2, prod3, prod4;
  logic [W-1:0]    mont_m3;
  logic [W2-1:0]   mont_mp4;
  logic [W+1:0]    mont_t5;
  logic [W:0]      mers_t4, mers_t5;
  logic [W+KW-1:0] ps_hk3;
  logic [TW-1:0]   ps_t4;
  logic [KW+16:0]  ps_m5;
  logic [W-1:0]    ps_lo5;
  logic [EW+KW-1:0] fr_lk3;
  logic [TW-1:0]   fr_t4;
  logic [EW+KW-1:0] fr_m5;
  logic [TW-1:0]   fr_s5;
  logic [W2-1:0]   pl_ll3;
  logic [W-1:0]    pl_lh3, pl_hl3;
  logic [W:0]      pl_u4;
  logic [W2:0]     pl_up5;
  logic [TW-1:0]   gm_t3, gm_t4, gm_t5;
  logic [TW-1:0]   t6;
  logic [W-1:0]    d6;
  logic            z6;

  // stage 3 products and first folds
  logic [W-1:0]     lo2, hi2;
  logic [W2-1:0]    mq2, lh2, hl2;
  logic [TW-1:0]    h2;
  logic [EW-1:0]    lem2;

  always_comb begin
    lo2  = prod2[W-1:0];
    hi2  = prod2[W2-1:W];
    mq2  = lo2 * q;
    lh2  = lo2 * rh;
    hl2  = hi2 * rl;
    h2   = TW'(hi2);
    lem2 = EW'(TW'(prod2)) & em;
  end

  // stage 4 second multiplies and folds
  logic [W-1:0]  lo3, hi3, cross3, xhi3;
  logic [W:0]    ms3;
  logic [TW-1:0] gh3;

  always_comb begin
    lo3    = prod3[W-1:0];
    hi3    = prod3[W2-1:W];
    ms3    = {1'b0, lo3} + {1'b0, hi3};
    cross3 = pl_lh3 + pl_hl3;
    xhi3   = pl_ll3[W2-1:W] + cross3;
    gh3    = gm_t3 >> W;
  end

  // stage 5 carries and last fold multiplies
  logic [W-1:0] lo4, hi4;
  logic [W:0]   lsum4;
  logic [16:0]  psh4;

  always_comb begin
    lo4   = prod4[W-1:0];
    hi4   = prod4[W2-1:W];
    lsum4 = {1'b0, lo4} + {1'b0, mont_mp4[W-1:0]};
    psh4  = 17'(ps_t4 >> W);
  end

  // stage 6 selection of the value to reduce and its modulus
  logic [TW-1:0] t_sel;
  logic [W-1:0]  d_sel;
  logic          bad_mode;
  logic [W:0]    pl_tt;

  always_comb begin
    pl_tt    = pl_up5[W2:W];
    d_sel    = p;
    bad_mode = 1'b0;
    case (mode)
      wmm_pkg::MODE_MONTGOMERY: t_sel = TW'(mont_t5);
      wmm_pkg::MODE_MERSENNE: begin
        t_sel = TW'(mers_t5);
        d_sel = '1;
      end
      wmm_pkg::MODE_PSEUDO:   t_sel = TW'(ps_m5) + TW'(ps_lo5);
      wmm_pkg::MODE_GENERAL:  t_sel = gm_t5;
      wmm_pkg::MODE_FRIENDLY: t_sel = TW'(fr_m5) + fr_s5;
      wmm_pkg::MODE_PLANTARD: t_sel = (pl_tt == {1'b0, p}) ? '0 : TW'(pl_tt);
      default: begin
        t_sel    = '0;
        bad_mode = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: operands
      a1 <= skid_v ? skid_a : operand_a[W-1:0];
      b1 <= skid_v ? skid_b : operand_b[W-1:0];
      // stage 2: full product
      prod2 <= a1 * b1;
      // stage 3
      prod3   <= prod2;
      mont_m3 <= mq2[W-1:0];
      ps_hk3  <= hi2 * fold_factor;
      fr_lk3  <= lem2 * fold_factor;
      pl_ll3  <= lo2 * rl;
      pl_lh3  <= lh2[W-1:0];
      pl_hl3  <= hl2[W-1:0];
      gm_t3   <= h2 + (h2 << shift_amount) + TW'(lo2);
      // stage 4
      prod4    <= prod3;
      mont_mp4 <= mont_m3 * p;
      mers_t4  <= {1'b0, ms3[W-1:0]} + (W+1)'(ms3[W]);
      ps_t4    <= TW'(ps_hk3) + TW'(lo3);
      fr_t4    <= TW'(fr_lk3) + (TW'(prod3) >> shift_amount);
      pl_u4    <= {1'b0, xhi3} + (W+1)'(1);
      gm_t4    <= gh3 + (gh3 << shift_amount) + TW'(gm_t3[W-1:0]);
      // stage 5
      mont_t5 <= (W+2)'(hi4) + (W+2)'(mont_mp4[W2-1:W]) + (W+2)'(lsum4[W]);
      mers_t5 <= mers_t4;
      ps_m5   <= psh4 * fold_factor;
      ps_lo5  <= ps_t4[W-1:0];
      fr_m5   <= (fr_t4[EW-1:0] & em) * fold_factor;
      fr_s5   <= fr_t4 >> shift_amount;
      pl_up5  <= pl_u4 * p;
      gm_t5   <= gm_t4;
      // stage 6
      t6 <= t_sel;
      d6 <= d_sel;
      z6 <= bad_mode || (d_sel == '0);
    end
  end

  // final remainder into [0, d6): the modulus p, or all ones in Mersenne mode
  logic [W-1:0] rem;

  wmm_mod_pipe #(
    .WIDTH (W)
  ) u_mod_pipe (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .in_valid   (v6),
    .dividend   (t6),
    .divisor    (d6),
    .force_zero (z6),
    .out_valid  (out_valid),
    .remainder  (rem)
  );

  assign residue = 32'(rem);

  // skid register only fills while a result is held at the output
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_valid && out_stall))
    else $error("skid filled without a held result");

  // skid item drains on the first moving cycle
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (adv && skid_v) |=> !skid_v)
    else $error("skid item not drained");

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(residue)))
    else $error("held result changed");

endmodule

[test/word_modular_multiplier_tb.sv]
`timescale 1ns / 1ps
// word_modular_multiplier_tb: self-checking bench for the word modular multiplier
// depends on wmm_pkg and word_modular_multiplier; a residue scoreboard predicts each item

module word_modular_multiplier_tb;

  // mode codes and register indexes beyond the package list; the block must answer the spare modes with zero
  localparam logic [2:0] MODE_SPARE_SIX   = 3'd6;
  localparam logic [2:0] MODE_SPARE_SEVEN = 3'd7;
  localparam logic [2:0] CFG_SPARE_FIVE   = 3'd5;
  localparam logic [2:0] CFG_SPARE_SIX    = 3'd6;
  localparam logic [2:0] CFG_SPARE_SEVEN  = 3'd7;
  localparam int CHECK_OK         = 0;
  localparam int CHECK_MISMATCH   = 1;
  localparam int CHECK_UNEXPECTED = 2;
  localparam int PIPE_LATENCY     = 21;

  // predicts residues from its own copy of the registers
  class residue_scoreboard;
    logic [2:0]  mode;
    logic [31:0] modulus;
    logic [63:0] inverse;
    logic [15:0] fold;
    logic [4:0]  shift;
    logic [31:0] residue_q[$];

    function void reset_regs();
      mode = wmm_pkg::MODE_MONTGOMERY;
      modulus = wmm_pkg::MODULUS_RESET;
      inverse = '0;
      fold = wmm_pkg::FOLD_RESET;
      shift = wmm_pkg::SHIFT_RESET;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] d);
      case (idx)
        wmm_pkg::CFG_REDUCTION_MODE:   mode = d[2:0];
        wmm_pkg::CFG_MODULUS:          modulus = d[31:0];
        wmm_pkg::CFG_INVERSE_CONSTANT: inverse = d;
        wmm_pkg::CFG_FOLD_FACTOR:      fold = d[15:0];
        wmm_pkg::CFG_SHIFT_AMOUNT:     shift = d[4:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] effective_modulus();
      return (mode == wmm_pkg::MODE_MERSENNE) ? 32'hFFFF_FFFF : modulus;
    endfunction

    function logic [63:0] rem_of(logic [63:0] t, logic [63:0] p);
      return (p == 0) ? 64'd0 : t % p;
    endfunction

    function logic [31:0] predict(logic [31:0] a, logic [31:0] b);
      logic [63:0] wm, prod, p, k, t, hi, m, mp, em, u, res;
      wm = 64'h0000_0000_FFFF_FFFF;
      prod = {32'd0, a} * {32'd0, b};
      p = {32'd0, modulus};
      k = {48'd0, fold};
      res = '0;
      case (mode)
        wmm_pkg::MODE_MONTGOMERY: begin
          m = ((prod & wm) * (inverse & wm)) & wm;
          mp = m * p;
          t = (prod >> 32) + (mp >> 32) + (((prod & wm) + (mp & wm)) >> 32);
          res = rem_of(t, p);
        end
        wmm_pkg::MODE_MERSENNE: begin
          t = (prod & wm) + (prod >> 32);
          t = (t & wm) + (t >> 32);
          res = rem_of(t, wm);
        end
        wmm_pkg::MODE_PSEUDO: begin
          t = (prod >> 32) * k + (prod & wm);
          t = (t >> 32) * k + (t & wm);
          res = rem_of(t, p);
        end
        wmm_pkg::MODE_GENERAL: begin
          hi = prod >> 32;
          t = hi + (hi << shift) + (prod & wm);
          hi = t >> 32;
          t = hi + (hi << shift) + (t & wm);
          res = rem_of(t, p);
        end
        wmm_pkg::MODE_FRIENDLY: begin
          em = (64'd1 << shift) - 64'd1;
          t = (prod & em) * k + (prod >> shift);
          t = (t & em) * k + (t >> shift);
          res = rem_of(t, p);
        end
        wmm_pkg::MODE_PLANTARD: begin
          u = ((prod * inverse) >> 32) + 64'd1;
          t = (u * p) >> 32;
          if (t == p) t = '0;
          res = rem_of(t, p);
        end
        default: res = '0;
      endcase
      return res[31:0];
    endfunction

    function void note_input(logic [31:0] a, logic [31:0] b);
      residue_q.push_back(predict(a, b));
    endfunction

    function int check_result(logic [31:0] got, output logic [31:0] want);
      want = '0;
      if (residue_q.size() == 0) return CHECK_UNEXPECTED;
      want = residue_q.pop_front();
      return (want === got) ? CHECK_OK : CHECK_MISMATCH;
    endfunction

    function int pending();
      return residue_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] operand_a = '0;
  logic [31:0] operand_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] residue;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  residue_scoreboard sb = new();
  int  error_count = 0;
  bit  tx_gaps_on = 1'b1;
  bit  rx_stalls_on = 1'b1;
  bit  rx_long_hold = 1'b0;
  int  stall_left = 0;

  word_modular_multiplier dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_stall(out_stall), .residue(residue),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // overall run limit
  initial begin
    #(12 * 400000);
    $display("word_modular_multiplier verification failed");
    $finish;
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: residue %h, predicted %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // receiver stall, with the long hold counted here
  initial begin
    forever begin
      @(negedge clk);
      if (rx_long_hold) begin
        stall_left = 300;
        rx_long_hold = 1'b0;
      end
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (rx_stalls_on && $urandom_range(0, 99) < 15) begin
        stall_left = gap_len() - 1;
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // result check
  always @(posedge clk) begin
    int status;
    logic [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      status = sb.check_result(residue, want);
      if (status == CHECK_UNEXPECTED) report("no item outstanding", residue, want);
      else if (status == CHECK_MISMATCH) report("wrong residue", residue, want);
    end
  end

  task automatic send_item(logic [31:0] a, logic [31:0] b);
    int gap;
    gap = (tx_gaps_on && $urandom_range(0, 99) < 30) ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid = 1'b1;
    operand_a = a;
    operand_b = b;
    do @(posedge clk); while (in_stall);
    sb.note_input(a, b);
  endtask

  // sender stops until every item has come back, then lets the pipe drain
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
  endtask

  // inverse of an odd value modulo 2^64 by newton iteration
  function automatic logic [63:0] inverse_of(logic [63:0] p);
    logic [63:0] x;
    x = p;
    repeat (6) x = x * (64'd2 - p * x);
    return x;
  endfunction

  task automatic write_all(logic [2:0] mode, logic [31:0] p, logic [15:0] k,
                           logic [4:0] s, logic [63:0] inv);
    write_reg(wmm_pkg::CFG_REDUCTION_MODE, {61'd0, mode});
    write_reg(wmm_pkg::CFG_MODULUS, {32'd0, p});
    write_reg(wmm_pkg::CFG_INVERSE_CONSTANT, inv);
    write_reg(wmm_pkg::CFG_FOLD_FACTOR, {48'd0, k});
    write_reg(wmm_pkg::CFG_SHIFT_AMOUNT, {59'd0, s});
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one setting per round: the extremes first, then random ones
  task automatic configure(int round);
    logic [2:0]  mode;
    logic [31:0] p;
    logic [15:0] k;
    logic [4:0]  s;
    logic [63:0] inv;
    bit          wrong_inv;
    mode = wmm_pkg::MODE_MONTGOMERY;
    p = $urandom | 32'd1;
    k = 16'($urandom_range(1, 65535));
    s = 5'($urandom_range(1, 31));
    wrong_inv = 1'b0;
    case (round)
      0:  p = 32'd3;
      1:  p = 32'hFFFF_FFFF;
      2:  begin mode = wmm_pkg::MODE_MERSENNE; p = '0; end
      3:  begin mode = wmm_pkg::MODE_PSEUDO; k = 16'd1; end
      4:  begin mode = wmm_pkg::MODE_PSEUDO; k = 16'hFFFF; end
      5:  begin mode = wmm_pkg::MODE_GENERAL; s = 5'd1; end
      6:  begin mode = wmm_pkg::MODE_GENERAL; s = 5'd31; end
      7:  begin mode = wmm_pkg::MODE_FRIENDLY; s = 5'd31; k = 16'd1; end
      8:  begin mode = wmm_pkg::MODE_FRIENDLY; s = 5'd1; k = 16'hFFFF; end
      9:  begin mode = wmm_pkg::MODE_PLANTARD; p = 32'd3; end
      10: begin mode = wmm_pkg::MODE_PLANTARD; p = 32'hFFFF_FFFF; end
      11: p = '0;
      12: mode = MODE_SPARE_SIX;
      13: mode = MODE_SPARE_SEVEN;
      14: begin mode = wmm_pkg::MODE_GENERAL; s = 5'd0; end
      15: begin mode = wmm_pkg::MODE_FRIENDLY; s = 5'd0; end
      16: wrong_inv = 1'b1;
      default: begin
        mode = 3'($urandom_range(0, 5));
        if (mode == wmm_pkg::MODE_FRIENDLY) s = 5'($urandom_range(1, 20));
      end
    endcase
    // derive the modulus from the shape that the mode expects
    if (round > 2 && round != 9 && round != 10 && round != 11) begin
      case (mode)
        wmm_pkg::MODE_PSEUDO:   p = 32'd0 - {16'd0, k | 16'd1};
        wmm_pkg::MODE_GENERAL:  p = 32'hFFFF_FFFF - (32'd1 << s);
        wmm_pkg::MODE_FRIENDLY: p = ({16'd0, k} << s) - 32'd1;
        default: ;
      endcase
      if (mode == wmm_pkg::MODE_PSEUDO) k = k | 16'd1;
    end
    inv = inverse_of({32'd0, p});
    if (mode == wmm_pkg::MODE_MONTGOMERY) inv = {$urandom, 32'd0 - inv[31:0]};
    if (wrong_inv || (mode != wmm_pkg::MODE_MONTGOMERY && mode != wmm_pkg::MODE_PLANTARD))
      inv = {$urandom, $urandom};
    write_all(mode, p, k, s, inv);
    // spare indexes and over-wide data, the block must ignore or mask them
    if (round == 13) begin
      write_reg(CFG_SPARE_FIVE, {$urandom, $urandom});
      write_reg(CFG_SPARE_SIX, {$urandom, $urandom});
      write_reg(CFG_SPARE_SEVEN, {$urandom, $urandom});
      write_reg(wmm_pkg::CFG_REDUCTION_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(wmm_pkg::CFG_SHIFT_AMOUNT, {$urandom, 27'h7FF_FFFF, 5'd3});
      write_reg(wmm_pkg::CFG_FOLD_FACTOR, {$urandom, 16'hABCD, 16'd5});
      @(negedge clk);
      cfg_valid = 1'b0;
    end
  endtask

  function automatic logic [31:0] pick_operand();
    logic [31:0] p;
    int r;
    p = sb.effective_modulus();
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 12) return p - 32'd1;
    if (r < 18) return 32'hFFFF_FFFF;
    if (r < 85 && p != 0) return $urandom % p;
    return $urandom;
  endfunction

  initial begin
    logic [31:0] p;
    int items;
    sb.reset_regs();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed items under the reset setting
    p = sb.effective_modulus();
    send_item('0, '0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item('0, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, '0);
    send_item(32'd1, 32'd1);
    send_item(p - 32'd1, p - 32'd1);
    send_item(p, p);
    send_item(32'hAAAA_AAAA, 32'h5555_5555);
    wait_idle();

    for (int round = 0; round < 23; round++) begin
      configure(round);
      tx_gaps_on = (round % 5) != 3;
      rx_stalls_on = (round % 7) != 4;
      items = (round < 17) ? 60 : 120;
      // a long receiver hold while the sender keeps offering items
      if (round == 17 || round == 20) begin
        tx_gaps_on = 1'b0;
        rx_long_hold = 1'b1;
      end
      for (int i = 0; i < items; i++) send_item(pick_operand(), pick_operand());
      wait_idle();
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("word_modular_multiplier verification clean");
    end else begin
      $display("word_modular_multiplier verification failed");
    end
    $finish;
  end

endmodule
